// File: rtl/slisr_pkg.sv
// shared constants and types for the static list insert/search/remove unit
package slisr_pkg;

    localparam int CAPACITY = 8;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef struct packed {
        logic valid;
        logic load;
        logic remove;
    } t_cell_ctrl;

endpackage

// File: rtl/static_list_insert_search_remove_unit.sv
// top level: row of list cells, request control and result register
// the result of an accepted request is registered into the output register on the next clock edge
// one request per cycle unless the output stalls; cells compare and shift in parallel
// the output register frees in the cycle its result is taken, so requests keep flowing
// reset (i_rst_n low, synchronous) empties the list and drops any pending result
// entries hold no reset; slots at or beyond the count are never compared
module static_list_insert_search_remove_unit
    import slisr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // value[31:0]
    input  logic [MODE_W-1:0] s_axis_tuser,   // mode[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // found_index[2:0], count[6:3], full_res[7]
    output logic              m_axis_tuser    // ok[0]
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              r_ok;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_res_count;
    logic              r_full;

    logic              w_accept;
    logic              w_found;
    logic              w_ok;
    logic              w_ins_ok;
    logic              w_rem_ok;
    logic [IDX_W-1:0]  w_pos;

    t_cell_ctrl        w_ctrl  [CAPACITY];
    logic [DATA_W-1:0] w_data  [CAPACITY];
    logic              w_hit   [CAPACITY];
    logic              w_first [CAPACITY];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_found       = w_hit[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_ctrl[gi].valid  = (CNT_W'(gi) < r_count);
            assign w_ctrl[gi].load   = w_ins_ok && (r_count == CNT_W'(gi));
            assign w_ctrl[gi].remove = w_rem_ok;

            slisr_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[gi]),
                .i_value     (s_axis_tdata),
                .i_next_data ((gi == CAPACITY - 1) ? w_data[gi] : w_data[(gi + 1) % CAPACITY]),
                .i_hit_prev  ((gi == 0) ? 1'b0 : w_hit[(gi + CAPACITY - 1) % CAPACITY]),
                .o_data      (w_data[gi]),
                .o_hit       (w_hit[gi]),
                .o_first     (w_first[gi])
            );
        end
    endgenerate

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_ok     = 1'b0;
        n_count  = r_count;
        case (s_axis_tuser)
            MODE_INSERT: begin
                w_ins_ok = w_accept && (r_count < CNT_W'(CAPACITY));
                w_ok     = (r_count < CNT_W'(CAPACITY));
                if (w_ins_ok) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_SEARCH: begin
                w_ok = w_found;
            end
            MODE_REMOVE: begin
                w_rem_ok = w_accept && w_found;
                w_ok     = w_found;
                if (w_rem_ok) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok        <= w_ok;
            r_idx       <= (w_ok && (s_axis_tuser != MODE_INSERT)) ? w_pos : '0;
            r_res_count <= n_count;
            r_full      <= (n_count == CNT_W'(CAPACITY));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_full, r_res_count, r_idx};
    assign m_axis_tuser  = r_ok;

endmodule

// File: rtl/slisr_cell.sv
// one list slot: holds an entry, compares it and shifts from its right neighbor
module slisr_cell
    import slisr_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_next_data,
    input  logic              i_hit_prev,
    output logic [DATA_W-1:0] o_data,
    output logic              o_hit,
    output logic              o_first
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_match;

    assign w_match = i_ctrl.valid && (r_data == i_value);
    assign o_hit   = i_hit_prev || w_match;
    assign o_first = w_match && !i_hit_prev;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_value;
        end else if (i_ctrl.remove && o_hit) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
